### rtl/core/tpc_pkg.sv
package tpc_pkg;

    localparam int COORD_W     = 24;
    localparam int COL_W       = 12;
    localparam int AREA_W      = 17;
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 24;

endpackage

### rtl/core/tpc_div.sv
module tpc_div import tpc_pkg::*; #(
    parameter int NW = 44,
    parameter int DW = 29,
    parameter int QW = 9
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quot
);

    // one quotient bit per stage, most significant first
    logic [NW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_q   [QW];

    logic [NW-1:0] w_rin [QW];
    logic [DW-1:0] w_din [QW];
    logic [QW-1:0] w_qin [QW];

    genvar gi;
    generate
        for (gi = 0; gi < QW; gi++) begin : g_stage
            logic [NW-1:0] w_cmp;
            logic          w_ge;

            if (gi == 0) begin : g_first
                assign w_rin[gi] = i_num;
                assign w_din[gi] = i_den;
                assign w_qin[gi] = '0;
            end else begin : g_next
                assign w_rin[gi] = r_rem[gi-1];
                assign w_din[gi] = r_den[gi-1];
                assign w_qin[gi] = r_q[gi-1];
            end

            assign w_cmp = NW'(w_din[gi]) << (QW - 1 - gi);
            assign w_ge  = (w_rin[gi] >= w_cmp);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[gi] <= {w_qin[gi][QW-2:0], w_ge};
                end
            end

            if (gi < QW - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[gi] <= w_ge ? (w_rin[gi] - w_cmp) : w_rin[gi];
                        r_den[gi] <= w_din[gi];
                    end
                end
            end
        end
    endgenerate

    assign o_quot = r_q[QW-1];

endmodule

### rtl/core/tpc_term.sv
module tpc_term import tpc_pkg::*; #(
    parameter int FRACTION_BITS = 8,
    parameter int CW            = 29
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [FRACTION_BITS:0]        i_h,
    input  logic signed [CW-1:0]          i_lo,
    input  logic signed [CW-1:0]          i_hi,
    input  logic signed [CW-1:0]          i_x,
    output logic [CW+FRACTION_BITS:0]     o_excess
);

    localparam int HW = FRACTION_BITS + 1;
    localparam int EW = CW + HW;
    localparam int NW = CW + HW + 1;

    // stage a: classify the column line against the edge
    logic          r_a_zero, r_a_full;
    logic [CW-1:0] r_a_d, r_a_span, r_a_g;
    logic [HW-1:0] r_a_h;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_zero <= (i_x >= i_hi);
            r_a_full <= (i_x <= i_lo);
            r_a_d    <= i_hi - i_x;
            r_a_span <= i_hi - i_lo;
            r_a_g    <= i_lo + i_hi - (i_x <<< 1);
            r_a_h    <= i_h;
        end
    end

    // stage b: dividend with half-span rounding, full-band product
    logic          r_b_zero, r_b_full;
    logic [CW-1:0] r_b_d, r_b_span;
    logic [NW-1:0] r_b_num;
    logic [EW-1:0] r_b_fullp;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_zero  <= r_a_zero;
            r_b_full  <= r_a_full;
            r_b_d     <= r_a_d;
            r_b_span  <= r_a_span;
            r_b_num   <= NW'(r_a_h) * NW'(r_a_d) + NW'(r_a_span >> 1);
            r_b_fullp <= EW'(r_a_h) * EW'(r_a_g);
        end
    end

    logic [HW-1:0] w_t;

    tpc_div #(
        .NW (NW),
        .DW (CW),
        .QW (HW)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  (r_b_num),
        .i_den  (r_b_span),
        .o_quot (w_t)
    );

    // side data kept in step with the divider
    logic          r_p_zero  [HW];
    logic          r_p_full  [HW];
    logic [CW-1:0] r_p_d     [HW];
    logic [EW-1:0] r_p_fullp [HW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_zero[0]  <= r_b_zero;
            r_p_full[0]  <= r_b_full;
            r_p_d[0]     <= r_b_d;
            r_p_fullp[0] <= r_b_fullp;
            for (int i = 1; i < HW; i++) begin
                r_p_zero[i]  <= r_p_zero[i-1];
                r_p_full[i]  <= r_p_full[i-1];
                r_p_d[i]     <= r_p_d[i-1];
                r_p_fullp[i] <= r_p_fullp[i-1];
            end
        end
    end

    // stage c: zero, the full-band product, or the triangle area from the crossing height
    logic [EW-1:0] r_c_ex;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            priority if (r_p_zero[HW-1]) begin
                r_c_ex <= '0;
            end else if (r_p_full[HW-1]) begin
                r_c_ex <= r_p_fullp[HW-1];
            end else begin
                r_c_ex <= EW'(w_t) * EW'(r_p_d[HW-1]);
            end
        end
    end

    assign o_excess = r_c_ex;

endmodule

### rtl/core/trapezoid_pixel_coverage.sv
// channel   dir  fields (lowest bit up)
// s_axis    in   bottom_y, top_y, left_low_x, left_high_x, right_low_x, right_high_x,
//                pixel_column (tdata, 160 bits)
// m_axis    out  covered_area (tdata, 24 bits)
//
// one transaction per cycle while m_axis is not stalled
// the pipeline holds one-bit-per-stage dividers, one per edge crossing
// i_rst_n clears the valid bits only, payload registers are not reset
// s_axis_tready is held low while i_rst_n is low
// a stall on m_axis holds every stage, s_axis_tready drops with it
module trapezoid_pixel_coverage import tpc_pkg::*; #(
    parameter int FRACTION_BITS = 8,
    parameter int IMAGE_WIDTH   = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // bottom_y, top_y, left_low_x, left_high_x, right_low_x, right_high_x, pixel_column
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // covered_area
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int HW  = FRACTION_BITS + 1;
    localparam int MXW = (COORD_W > FRACTION_BITS + 14) ? COORD_W : FRACTION_BITS + 14;
    localparam int CW  = MXW + 2;
    localparam int EW  = CW + HW;
    localparam int SW  = EW + 3;
    localparam int TL  = FRACTION_BITS + 4;
    localparam int CLW = 2 * FRACTION_BITS + 2;
    localparam int SH  = 2 * FRACTION_BITS + 1 - 16;
    localparam logic [SW-1:0] FULL_S = SW'(1) << (2 * FRACTION_BITS + 1);

    logic w_en;
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en && i_rst_n;

    // input unpacking
    logic signed [COORD_W-1:0] w_yb, w_yt, w_a, w_b, w_c, w_e;
    logic [COL_W-1:0]          w_col;
    logic signed [COORD_W:0]   w_dy;
    logic [HW-1:0]             w_h;
    logic signed [CW-1:0]      w_x4;

    assign w_yb  = s_axis_tdata[0*COORD_W +: COORD_W];
    assign w_yt  = s_axis_tdata[1*COORD_W +: COORD_W];
    assign w_a   = s_axis_tdata[2*COORD_W +: COORD_W];
    assign w_b   = s_axis_tdata[3*COORD_W +: COORD_W];
    assign w_c   = s_axis_tdata[4*COORD_W +: COORD_W];
    assign w_e   = s_axis_tdata[5*COORD_W +: COORD_W];
    assign w_col = s_axis_tdata[6*COORD_W +: COL_W];

    assign w_dy = (COORD_W+1)'(w_yt) - (COORD_W+1)'(w_yb);
    assign w_x4 = CW'({w_col, {FRACTION_BITS{1'b0}}});

    always_comb begin
        priority if (w_dy[COORD_W]) begin
            w_h = '0;
        end else if (w_dy > (COORD_W+1)'(1 << FRACTION_BITS)) begin
            w_h = HW'(1 << FRACTION_BITS);
        end else begin
            w_h = w_dy[HW-1:0];
        end
    end

    // stage 0: edges in ascending order, height, column lines
    logic                 r_v0;
    logic                 r_oob0;
    logic [HW-1:0]        r_h0;
    logic signed [CW-1:0] r_a, r_b, r_c, r_e, r_x4, r_x5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_oob0 <= (int'(w_col) >= IMAGE_WIDTH);
            r_h0   <= w_h;
            r_a    <= (w_a > w_b) ? CW'(w_b) : CW'(w_a);
            r_b    <= (w_a > w_b) ? CW'(w_a) : CW'(w_b);
            r_c    <= (w_c > w_e) ? CW'(w_e) : CW'(w_c);
            r_e    <= (w_c > w_e) ? CW'(w_c) : CW'(w_e);
            r_x4   <= w_x4;
            r_x5   <= w_x4 + CW'(1 << FRACTION_BITS);
        end
    end

    // right-edge slivers are left-edge slivers of the mirrored trapezoid
    logic [EW-1:0] w_l4, w_l5, w_r4, w_r5;

    tpc_term #(.FRACTION_BITS(FRACTION_BITS), .CW(CW)) u_l4 (
        .i_clk (i_clk), .i_en (w_en), .i_h (r_h0),
        .i_lo (r_a), .i_hi (r_b), .i_x (r_x4), .o_excess (w_l4)
    );

    tpc_term #(.FRACTION_BITS(FRACTION_BITS), .CW(CW)) u_l5 (
        .i_clk (i_clk), .i_en (w_en), .i_h (r_h0),
        .i_lo (r_a), .i_hi (r_b), .i_x (r_x5), .o_excess (w_l5)
    );

    tpc_term #(.FRACTION_BITS(FRACTION_BITS), .CW(CW)) u_r5 (
        .i_clk (i_clk), .i_en (w_en), .i_h (r_h0),
        .i_lo (-r_e), .i_hi (-r_c), .i_x (-r_x5), .o_excess (w_r5)
    );

    tpc_term #(.FRACTION_BITS(FRACTION_BITS), .CW(CW)) u_r4 (
        .i_clk (i_clk), .i_en (w_en), .i_h (r_h0),
        .i_lo (-r_e), .i_hi (-r_c), .i_x (-r_x4), .o_excess (w_r4)
    );

    // valid, height and range flag alongside the term pipelines
    logic          r_vp [TL];
    logic [HW-1:0] r_hp [TL];
    logic          r_op [TL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TL; i++) begin
                r_vp[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vp[0] <= r_v0;
            for (int i = 1; i < TL; i++) begin
                r_vp[i] <= r_vp[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hp[0] <= r_h0;
            r_op[0] <= r_oob0;
            for (int i = 1; i < TL; i++) begin
                r_hp[i] <= r_hp[i-1];
                r_op[i] <= r_op[i-1];
            end
        end
    end

    // sum stage: doubled area
    logic          r_sv, r_soob;
    logic [SW-1:0] r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (w_en) begin
            r_sv <= r_vp[TL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_soob <= r_op[TL-1];
            r_s    <= (SW'(r_hp[TL-1]) << (FRACTION_BITS + 1))
                      - SW'(w_l4) + SW'(w_l5) - SW'(w_r5) + SW'(w_r4);
        end
    end

    // clamp and scale to 1/65536 units
    logic [CLW-1:0]    w_cl;
    logic [AREA_W-1:0] w_sc;

    always_comb begin
        priority if (r_s[SW-1]) begin
            w_cl = '0;
        end else if ($signed(r_s) > $signed(FULL_S)) begin
            w_cl = FULL_S[CLW-1:0];
        end else begin
            w_cl = r_s[CLW-1:0];
        end
    end

    generate
        if (SH > 0) begin : g_down
            logic [CLW:0] w_rnd;
            assign w_rnd = {1'b0, w_cl} + ((CLW+1)'(1) << (SH - 1));
            assign w_sc  = w_rnd[SH +: AREA_W];
        end else if (SH == 0) begin : g_same
            assign w_sc = w_cl[AREA_W-1:0];
        end else begin : g_up
            assign w_sc = AREA_W'(w_cl) << (-SH);
        end
    endgenerate

    logic              r_ov;
    logic [AREA_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= r_soob ? '0 : w_sc;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

`ifndef SYNTHESIS
    a_area_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[AREA_W-1:0] <= AREA_W'(65536)))
        else $error("covered area above one pixel");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

    a_sum_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_sv) |=> m_axis_tvalid)
        else $error("sum stage transaction lost before output");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_vp[TL-1]) && $stable(r_sv)))
        else $error("pipeline moved during stall");
`endif

endmodule

### bench/testbench.sv
module testbench import tpc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC      = 8;
    localparam int IMG_W     = 4096;
    localparam int LATENCY   = FRAC + 7;
    localparam int WATCHDOG  = 5000;
    localparam int N_RANDOM  = 800;

    typedef struct packed {
        logic [COL_W-1:0]   pixel_column;
        logic [COORD_W-1:0] right_high_x;
        logic [COORD_W-1:0] right_low_x;
        logic [COORD_W-1:0] left_high_x;
        logic [COORD_W-1:0] left_low_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] bottom_y;
    } trap_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    trap_t              pending_traps[$];
    logic [AREA_W-1:0]  expected_areas[$];
    int                 n_errors = 0;
    int                 idle_cycles = 0;
    int                 cycle_no = 0;
    int                 ready_cycles = 0;
    bit                 stim_done = 1'b0;
    bit                 in_flight = 1'b0;

    trapezoid_pixel_coverage #(.FRACTION_BITS(FRAC), .IMAGE_WIDTH(IMG_W)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // doubled sliver area left of a left edge
    function automatic longint left_sliver(longint h, longint lo, longint hi, longint xl);
        longint d, span, t;
        if (xl >= hi) return 0;
        if (xl <= lo) return h * (lo + hi - 2 * xl);
        d = hi - xl;
        span = hi - lo;
        t = (h * d + span / 2) / span;
        return t * d;
    endfunction

    function automatic longint right_sliver(longint h, longint lo, longint hi, longint xl);
        longint d, span, t;
        if (xl <= lo) return 0;
        if (xl >= hi) return h * (2 * xl - lo - hi);
        d = xl - lo;
        span = hi - lo;
        t = (h * d + span / 2) / span;
        return t * d;
    endfunction

    function automatic logic [AREA_W-1:0] coverage_of(trap_t tr);
        longint yb, yt, a, b, c, e, k, h, x4, x5, s, one, full;
        int sh;
        yb = longint'(signed'(tr.bottom_y));
        yt = longint'(signed'(tr.top_y));
        a  = longint'(signed'(tr.left_low_x));
        b  = longint'(signed'(tr.left_high_x));
        c  = longint'(signed'(tr.right_low_x));
        e  = longint'(signed'(tr.right_high_x));
        one = longint'(1) << FRAC;
        if (tr.pixel_column >= IMG_W) return '0;
        if (a > b) begin k = a; a = b; b = k; end
        if (c > e) begin k = c; c = e; e = k; end
        h = yt - yb;
        if (h < 0) h = 0;
        if (h > one) h = one;
        x4 = longint'(tr.pixel_column) * one;
        x5 = x4 + one;
        s = 2 * h * one - left_sliver(h, a, b, x4) + left_sliver(h, a, b, x5)
            - right_sliver(h, c, e, x5) + right_sliver(h, c, e, x4);
        full = longint'(1) << (2 * FRAC + 1);
        if (s < 0) s = 0;
        if (s > full) s = full;
        sh = 2 * FRAC + 1 - 16;
        if (sh > 0) s = (s + (longint'(1) << (sh - 1))) >>> sh;
        else if (sh < 0) s = s <<< (-sh);
        return s[AREA_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] near_coord(int base);
        return COORD_W'(base + $signed($urandom_range(0, 1600)) - 800);
    endfunction

    // mostly well-formed trapezoids around the chosen column, some raw noise
    function automatic trap_t random_trap();
        trap_t tr;
        int col, base, yb;
        col = $urandom_range(0, IMG_W - 1);
        base = col * 256;
        yb = $signed($urandom()) >>> 9;
        tr.pixel_column = COL_W'(col);
        if ($urandom_range(0, 9) < 8) begin
            tr.bottom_y = COORD_W'(yb);
            tr.top_y = COORD_W'(yb + $signed($urandom_range(0, 300)) - 20);
            tr.left_low_x = near_coord(base - 300);
            tr.left_high_x = ($urandom_range(0, 7) == 0) ? tr.left_low_x
                                                          : near_coord(base - 300);
            tr.right_low_x = near_coord(base + 500);
            tr.right_high_x = ($urandom_range(0, 7) == 0) ? tr.right_low_x
                                                           : near_coord(base + 500);
        end else begin
            tr = trap_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        end
        return tr;
    endfunction

    function automatic trap_t make_trap(int yb, int yt, int a, int b, int c, int e, int col);
        trap_t tr;
        tr.bottom_y = COORD_W'(yb);
        tr.top_y = COORD_W'(yt);
        tr.left_low_x = COORD_W'(a);
        tr.left_high_x = COORD_W'(b);
        tr.right_low_x = COORD_W'(c);
        tr.right_high_x = COORD_W'(e);
        tr.pixel_column = COL_W'(col);
        return tr;
    endfunction

    function automatic void queue_trap(trap_t tr);
        pending_traps.insert(pending_traps.size(), tr);
    endfunction

    initial begin
        // full pixel, partial, negative and over-tall height, edges crossing, vertical edges, extreme coordinates
        queue_trap(make_trap(0, 256, 0, 0, 512, 512, 0));
        queue_trap(make_trap(0, 256, 100, 300, 400, 700, 1));
        queue_trap(make_trap(256, 0, 0, 0, 512, 512, 0));
        queue_trap(make_trap(0, 1000, 0, 0, 512, 512, 0));
        queue_trap(make_trap(0, 256, 700, 300, 200, 100, 1));
        queue_trap(make_trap(0, 256, 300, 300, 400, 400, 1));
        queue_trap(make_trap(0, 256, 0, 0, 512, 512, 3000));
        queue_trap(make_trap(0, 256, -8388608, 8388607, -8388608, 8388607, 4095));
        queue_trap(make_trap(-8388608, 8388607, -8388608, -8388608,
                             8388607, 8388607, 4095));
        queue_trap(make_trap(8388607, -8388608, 8388607, 8388607,
                             8388607, 8388607, 0));
        queue_trap(make_trap(0, 128, 250, 270, 260, 1000, 0));
        queue_trap(make_trap(0, 256, 1, 255, 257, 511, 1));
        queue_trap(make_trap(0, 256, -500, 900, -100, 1200, 2));
        queue_trap(make_trap(0, 1, 256, 512, 256, 512, 1));
        queue_trap(make_trap(0, 256, 255, 257, 258, 260, 0));
        queue_trap(make_trap(0, 256, -1, -1, -1, -1, 0));
        for (int i = 0; i < N_RANDOM; i++) queue_trap(random_trap());
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_flight) begin
                if (pending_traps.size() > 0 && (cycle_no inside {[600:1000]}
                                                 || $urandom_range(0, 99) >= 15)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= IN_TDATA_W'(pending_traps.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (pending_traps.size() == 0) stim_done <= 1'b1;
                end
            end
        end
    end

    // receiver: long hold-off to back the pipeline up, then a stretch without idling
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            ready_cycles <= ready_cycles + 1;
            if (ready_cycles inside {[300:400]}) m_axis_tready <= 1'b0;
            else if (ready_cycles inside {[600:1000]}) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 99) >= 15);
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        logic [AREA_W-1:0] want;
        cycle_no <= cycle_no + 1;
        in_flight = s_axis_tvalid && s_axis_tready && i_rst_n;
        if (in_flight)
            expected_areas.insert(expected_areas.size(),
                                  coverage_of(trap_t'(s_axis_tdata)));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_areas.size() == 0) begin
                $display("%0t: unexpected result, actual %0d", $time, m_axis_tdata);
                n_errors++;
            end else begin
                want = expected_areas.pop_front();
                if (m_axis_tdata !== OUT_TDATA_W'(want)) begin
                    $display("%0t: covered_area expected %0d actual %0d",
                             $time, want, m_axis_tdata);
                    n_errors++;
                end
            end
        end
        if (in_flight || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (stim_done && expected_areas.size() == 0);
        repeat (LATENCY * 4) @(posedge i_clk);
        if (n_errors == 0 && expected_areas.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG);
        $display("%0t: timeout", $time);
        $display("FAILED: results differ");
        $finish;
    end
endmodule
